// ===== rtl/core/plk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plk_pkg
// Shared constants, codes and controller/datapath interface types for the
// positional list engine.
// ----------------------------------------------------------------------------
package plk_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_PRIOR  = 3'd3;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP_PRIME,
    S_UP,
    S_UP_NEW,
    S_CAPTURE,
    S_DN,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    RA_LOOKUP,
    RA_BELOW,
    RA_BELOW2,
    RA_ABOVE,
    RA_ABOVE2
  } rd_sel_t;

  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    idx_init;
    logic    idx_dec;
    logic    idx_inc;
    logic    cap_rv;
    logic    commit;
  } plk_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_delete;
    logic op_ok;
    logic rd_op;
    logic shift_none;
    logic up_last;
    logic dn_last;
  } plk_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/plk_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plk_datapath
// Word store, count, request and result registers, range checks and the
// shift index used while words move up or down one slot per cycle.
// ----------------------------------------------------------------------------
module plk_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire plk_pkg::plk_cmd_t                  cmd,
  output plk_pkg::plk_stat_t                      stat,
  input  wire logic [plk_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic      [plk_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import plk_pkg::*;

  logic [DATA_W-1:0] words_r [CAPACITY];
  logic [DATA_W-1:0] rdata_r;

  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0] rv_r;

  logic [STAT_W-1:0] res_status_r;
  logic [DATA_W-1:0] res_rv_r;
  logic [CNT_W-1:0]  res_count_r;
  logic              res_empty_r;

  logic [CNT_W-1:0]  pos_c;
  logic              pos_nz, pos_le, pos_lt, ok;
  logic [STAT_W-1:0] status_code;
  logic [ADDR_W-1:0] lookup_addr, rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign pos_c  = CNT_W'(pos_r);
  assign pos_nz = (pos_c != '0);
  assign pos_le = (pos_c <= count_r);
  assign pos_lt = (pos_c < count_r);

  always_comb begin
    unique case (op_r) inside
      OP_INSERT: ok = pos_le && (count_r != CAP_CNT);
      OP_DELETE,
      OP_GET:    ok = pos_nz && pos_le;
      OP_PRIOR:  ok = (pos_c > CNT_W'(1)) && pos_le;
      OP_NEXT:   ok = pos_nz && pos_lt;
      OP_CLEAR:  ok = 1'b1;
      default:   ok = 1'b0;
    endcase
  end

  always_comb begin
    if (ok) begin
      status_code = ST_OK;
    end else if ((op_r == OP_INSERT) && pos_le) begin
      status_code = ST_FULL;
    end else begin
      status_code = ST_RANGE;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ok) begin
      case (op_r)
        OP_INSERT: count_nxt = count_r + CNT_W'(1);
        OP_DELETE: count_nxt = count_r - CNT_W'(1);
        OP_CLEAR:  count_nxt = '0;
        default:   count_nxt = count_r;
      endcase
    end
  end

  always_comb begin
    case (op_r)
      OP_PRIOR: lookup_addr = ADDR_W'(pos_c - CNT_W'(2));
      OP_NEXT:  lookup_addr = ADDR_W'(pos_c);
      default:  lookup_addr = ADDR_W'(pos_c - CNT_W'(1));
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RA_BELOW:  rd_addr = ADDR_W'(idx_r - CNT_W'(1));
      RA_BELOW2: rd_addr = ADDR_W'(idx_r - CNT_W'(2));
      RA_ABOVE:  rd_addr = ADDR_W'(idx_r + CNT_W'(1));
      RA_ABOVE2: rd_addr = ADDR_W'(idx_r + CNT_W'(2));
      default:   rd_addr = lookup_addr;
    endcase
  end

  assign wr_addr = cmd.wr_new ? ADDR_W'(pos_c) : ADDR_W'(idx_r);
  assign wr_data = cmd.wr_new ? val_r : rdata_r;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_init) begin
      idx_nxt = (op_r == OP_INSERT) ? count_r : (pos_c - CNT_W'(1));
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - CNT_W'(1);
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  assign stat.is_insert  = (op_r == OP_INSERT);
  assign stat.is_delete  = (op_r == OP_DELETE);
  assign stat.op_ok      = ok;
  assign stat.rd_op      = (op_r == OP_DELETE) || (op_r == OP_GET) ||
                           (op_r == OP_PRIOR) || (op_r == OP_NEXT);
  assign stat.shift_none = (pos_c == count_r);
  assign stat.up_last    = ((idx_r - CNT_W'(1)) == pos_c);
  assign stat.dn_last    = ((idx_r + CNT_W'(2)) == count_r);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      words_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= words_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= in_tdata[2:0];
      pos_r <= in_tdata[10:3];
      val_r <= in_tdata[42:11];
    end
    idx_r <= idx_nxt;
    if (cmd.load_req) begin
      rv_r <= '0;
    end else if (cmd.cap_rv) begin
      rv_r <= rdata_r;
    end
    if (cmd.commit) begin
      res_status_r <= status_code;
      res_rv_r     <= rv_r;
      res_count_r  <= count_nxt;
      res_empty_r  <= (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  assign out_tdata = {5'b0, res_empty_r, res_count_r, res_rv_r, res_status_r};

endmodule
`default_nettype wire

// ===== rtl/core/plk_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plk_ctrl
// Request sequencer: decodes the held request, steps the store through the
// lookup and shift passes, and owns the result valid flag.
// ----------------------------------------------------------------------------
module plk_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire plk_pkg::plk_stat_t stat,
  output plk_pkg::plk_cmd_t       cmd
);
  import plk_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.idx_init = 1'b1;
        if (!stat.op_ok) begin
          state_nxt = S_FINISH;
        end else if (stat.is_insert) begin
          if (stat.shift_none) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_new = 1'b1;
            state_nxt  = S_FINISH;
          end else begin
            state_nxt = S_UP_PRIME;
          end
        end else if (stat.rd_op) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_LOOKUP;
          state_nxt  = S_CAPTURE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_UP_PRIME: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_BELOW;
        state_nxt  = S_UP;
      end
      S_UP: begin
        cmd.wr_en = 1'b1;
        if (stat.up_last) begin
          state_nxt = S_UP_NEW;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RA_BELOW2;
          cmd.idx_dec = 1'b1;
        end
      end
      S_UP_NEW: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_new = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_CAPTURE: begin
        cmd.cap_rv = 1'b1;
        if (stat.is_delete && !stat.shift_none) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_ABOVE;
          state_nxt  = S_DN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DN: begin
        cmd.wr_en = 1'b1;
        if (stat.dn_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RA_ABOVE2;
          cmd.idx_inc = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/positional_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit words with insert, delete, get, prior, next
// and clear requests, one result beat per request beat.
//
// Input stream in_*: one request per beat (opcode, position, new_value).
// Output stream out_*: one result per request (status, read_value, count,
// is_empty), held in an output register.
// Steps per request: clear, rejected requests and an insert at the tail go
// from decode straight to the finish step; get/prior/next/delete read the
// word in a lookup and a capture step, and a delete that moves k words then
// shifts them down; an insert that moves k >= 1 words primes a read, shifts
// them up and then writes the new word. Words move one slot per cycle through
// the single write port of the word store, so k = count - position sets the throughput.
// A new request is taken while the previous result still waits; the engine
// then holds the finished result in its last step until out_tready frees
// the output register.
// Reset empties the list and drops any pending result; store contents are
// not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module positional_list_engine (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [2:0] opcode, [10:3] position, [42:11] new_value
  input  wire logic [plk_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [1:0] status, [33:2] read_value, [41:34] count, [42] is_empty
  output logic      [plk_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import plk_pkg::*;

  plk_cmd_t  cmd;
  plk_stat_t stat;

  plk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  plk_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of positional_list_engine. A short table of requests
// covers empty-list errors, word extremes, every opcode and the unused ones.
// Random traffic follows: mixed requests around the current count, plus
// passes that fill the list to capacity and probe it there. Each accepted
// request is run through a local list model, and every result beat is
// compared field by field in order. Both sides idle at random, and the
// receiver stalls once for a long stretch while requests keep coming.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [plk_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [plk_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_FROM   = 1250;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [plk_pkg::STAT_W-1:0] status;
    logic [plk_pkg::DATA_W-1:0] rd;
    logic [plk_pkg::CNT_W-1:0]  cnt;
    logic                       empty;
  } list_result_t;

  typedef struct packed {
    logic [plk_pkg::OP_W-1:0]   op;
    logic [plk_pkg::POS_W-1:0]  pos;
    logic [plk_pkg::DATA_W-1:0] val;
    logic                       typed;
    list_result_t               want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [plk_pkg::IN_TDATA_W-1:0] in_tdata;   // [2:0] opcode, [10:3] position, [42:11] new_value
  logic out_tvalid;
  logic out_tready;
  logic [plk_pkg::OUT_TDATA_W-1:0] out_tdata; // [1:0] status, [33:2] read_value, [41:34] count, [42] is_empty

  logic signed [plk_pkg::DATA_W-1:0] list_words [0:plk_pkg::CAPACITY-1];
  int list_len = 0;
  list_result_t pending_results [$];
  table_row_t directed [$];

  int fail_cnt = 0;
  int accepted = 0;
  int rand_items = 0;
  int fills = 0;
  int full_seen = 0;
  int range_seen = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  positional_list_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

  task automatic apply_request(input logic [plk_pkg::OP_W-1:0] op,
                               input logic [plk_pkg::POS_W-1:0] pos,
                               input logic [plk_pkg::DATA_W-1:0] val,
                               output list_result_t res);
    int p;
    int i;
    p = pos;
    res.status = plk_pkg::ST_RANGE;
    res.rd = '0;
    case (op)
      plk_pkg::OP_INSERT: begin
        if (p > list_len) begin
          res.status = plk_pkg::ST_RANGE;
        end else if (list_len >= plk_pkg::CAPACITY) begin
          res.status = plk_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = val;
          list_len++;
          res.status = plk_pkg::ST_OK;
        end
      end
      plk_pkg::OP_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          res.rd = list_words[p-1];
          for (i = p - 1; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          res.status = plk_pkg::ST_OK;
        end
      end
      plk_pkg::OP_GET: begin
        if (p >= 1 && p <= list_len) begin
          res.rd = list_words[p-1];
          res.status = plk_pkg::ST_OK;
        end
      end
      plk_pkg::OP_PRIOR: begin
        if (p >= 2 && p <= list_len) begin
          res.rd = list_words[p-2];
          res.status = plk_pkg::ST_OK;
        end
      end
      plk_pkg::OP_NEXT: begin
        if (p >= 1 && p < list_len) begin
          res.rd = list_words[p];
          res.status = plk_pkg::ST_OK;
        end
      end
      plk_pkg::OP_CLEAR: begin
        list_len = 0;
        res.status = plk_pkg::ST_OK;
      end
      default: res.status = plk_pkg::ST_RANGE;
    endcase
    res.cnt = 8'(list_len);
    res.empty = (list_len == 0);
  endtask

  // called at a falling edge; returns at the rising edge that took the beat
  task automatic offer(input logic [plk_pkg::OP_W-1:0] op,
                       input logic [plk_pkg::POS_W-1:0] pos,
                       input logic [plk_pkg::DATA_W-1:0] val,
                       input logic typed,
                       input list_result_t want);
    list_result_t got;
    if (!quiet && !(hold_req && !hold_done) && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, val, pos, op};
    do @(posedge clk); while (!in_tready);
    apply_request(op, pos, val, got);
    if (typed) got = want;
    if (got.status == plk_pkg::ST_FULL) full_seen++;
    if (got.status == plk_pkg::ST_RANGE) range_seen++;
    pending_results.push_back(got);
    accepted++;
  endtask

  task automatic issue(input logic [plk_pkg::OP_W-1:0] op,
                       input logic [plk_pkg::POS_W-1:0] pos,
                       input logic [plk_pkg::DATA_W-1:0] val);
    @(negedge clk);
    offer(op, pos, val, 1'b0, '0);
    rand_items++;
    if (rand_items == HOLD_AT) hold_req = 1'b1;
    if (rand_items >= QUIET_FROM) quiet = 1'b1;
  endtask

  function automatic logic [plk_pkg::POS_W-1:0] pick_pos(input int lo);
    int r;
    int hi;
    r = $urandom_range(0, 9);
    hi = (list_len < lo) ? lo : list_len;
    if (r < 7) return 8'($urandom_range(lo, hi));
    if (r == 7) begin
      case ($urandom_range(0, 2))
        0: return 8'(0);
        1: return 8'(list_len);
        default: return 8'(list_len + 1);
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [plk_pkg::DATA_W-1:0] pick_val();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;

    directed.push_back('{plk_pkg::OP_GET, 8'd1, 32'd0, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd0, 1'b1}});
    directed.push_back('{plk_pkg::OP_DELETE, 8'd1, 32'd0, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd0, 1'b1}});
    directed.push_back('{plk_pkg::OP_INSERT, 8'd1, 32'd5, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd0, 1'b1}});
    directed.push_back('{plk_pkg::OP_INSERT, 8'd255, 32'hffff_ffff, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd0, 1'b1}});
    directed.push_back('{plk_pkg::OP_PRIOR, 8'd2, 32'd0, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd0, 1'b1}});
    directed.push_back('{plk_pkg::OP_NEXT, 8'd0, 32'd0, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd0, 1'b1}});
    directed.push_back('{plk_pkg::OP_INSERT, 8'd0, 32'h7fff_ffff, 1'b1,
                         '{plk_pkg::ST_OK, 32'd0, 8'd1, 1'b0}});
    directed.push_back('{plk_pkg::OP_INSERT, 8'd1, 32'h8000_0000, 1'b1,
                         '{plk_pkg::ST_OK, 32'd0, 8'd2, 1'b0}});
    directed.push_back('{plk_pkg::OP_INSERT, 8'd1, 32'hffff_ffff, 1'b0, '0});
    directed.push_back('{plk_pkg::OP_INSERT, 8'd0, 32'd0, 1'b0, '0});
    directed.push_back('{plk_pkg::OP_GET, 8'd1, 32'd0, 1'b0, '0});
    directed.push_back('{plk_pkg::OP_GET, 8'd4, 32'd0, 1'b0, '0});
    directed.push_back('{plk_pkg::OP_GET, 8'd5, 32'd0, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd4, 1'b0}});
    directed.push_back('{plk_pkg::OP_GET, 8'd0, 32'd0, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd4, 1'b0}});
    directed.push_back('{plk_pkg::OP_PRIOR, 8'd1, 32'd0, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd4, 1'b0}});
    directed.push_back('{plk_pkg::OP_PRIOR, 8'd4, 32'd0, 1'b0, '0});
    directed.push_back('{plk_pkg::OP_NEXT, 8'd3, 32'd0, 1'b0, '0});
    directed.push_back('{plk_pkg::OP_NEXT, 8'd4, 32'd0, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd4, 1'b0}});
    directed.push_back('{plk_pkg::OP_DELETE, 8'd4, 32'd0, 1'b0, '0});
    directed.push_back('{plk_pkg::OP_DELETE, 8'd0, 32'd0, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd3, 1'b0}});
    directed.push_back('{OP_SPARE_A, 8'd1, 32'd0, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd3, 1'b0}});
    directed.push_back('{OP_SPARE_B, 8'd255, 32'hffff_ffff, 1'b1,
                         '{plk_pkg::ST_RANGE, 32'd0, 8'd3, 1'b0}});
    directed.push_back('{plk_pkg::OP_DELETE, 8'd1, 32'd0, 1'b0, '0});
    directed.push_back('{plk_pkg::OP_CLEAR, 8'd0, 32'd0, 1'b1,
                         '{plk_pkg::ST_OK, 32'd0, 8'd0, 1'b1}});
    directed.push_back('{plk_pkg::OP_CLEAR, 8'd77, 32'h1234_5678, 1'b1,
                         '{plk_pkg::ST_OK, 32'd0, 8'd0, 1'b1}});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) begin
      @(negedge clk);
      offer(directed[k].op, directed[k].pos, directed[k].val,
            directed[k].typed, directed[k].want);
    end

    while (rand_items < RANDOM_ITEMS) begin
      if (fills == 0 || $urandom_range(0, 15) == 0) begin
        // fill to capacity, then probe the full list
        fills++;
        issue(plk_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), pick_val());
        while (list_len < plk_pkg::CAPACITY)
          issue(plk_pkg::OP_INSERT, 8'($urandom_range(0, list_len)), pick_val());
        issue(plk_pkg::OP_INSERT, 8'($urandom_range(0, list_len)), pick_val());
        issue(plk_pkg::OP_INSERT, 8'(list_len), pick_val());
        issue(plk_pkg::OP_INSERT, 8'($urandom_range(list_len + 1, 255)), pick_val());
        issue(plk_pkg::OP_GET, 8'(list_len), pick_val());
        issue(plk_pkg::OP_PRIOR, 8'(list_len), pick_val());
        issue(plk_pkg::OP_NEXT, 8'(list_len - 1), pick_val());
        issue(plk_pkg::OP_NEXT, 8'(list_len), pick_val());
        issue(plk_pkg::OP_DELETE, 8'(list_len + 1), pick_val());
        issue(plk_pkg::OP_DELETE, 8'(list_len), pick_val());
        issue(plk_pkg::OP_DELETE, 8'd1, pick_val());
      end else begin
        repeat (30) begin
          int r;
          r = $urandom_range(0, 99);
          if (r < 40)
            issue(plk_pkg::OP_INSERT, pick_pos(0), pick_val());
          else if (r < 62)
            issue(plk_pkg::OP_DELETE, pick_pos(1), pick_val());
          else if (r < 72)
            issue(plk_pkg::OP_GET, pick_pos(1), pick_val());
          else if (r < 80)
            issue(plk_pkg::OP_PRIOR, pick_pos(2), pick_val());
          else if (r < 88)
            issue(plk_pkg::OP_NEXT, pick_pos(1), pick_val());
          else if (r < 91)
            issue(plk_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), pick_val());
          else if (r < 95)
            issue($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                  8'($urandom_range(0, 255)), pick_val());
          else
            issue(plk_pkg::OP_INSERT, 8'($urandom_range(0, 255)), pick_val());
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d requests (%0d from the table), %0d fills to capacity",
             accepted, directed.size(), fills);
    $display("Expected statuses seen: %0d list full, %0d out of range",
             full_seen, range_seen);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver: random back-pressure, one long hold-off, none near the end
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    list_result_t exp_res;
    list_result_t act_res;
    if (rst_n && out_tvalid && out_tready) begin
      act_res.status = out_tdata[1:0];
      act_res.rd     = out_tdata[33:2];
      act_res.cnt    = out_tdata[41:34];
      act_res.empty  = out_tdata[42];
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding: %h", out_tdata);
        fail_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (act_res.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, act_res.status);
          fail_cnt++;
        end
        if (act_res.rd !== exp_res.rd) begin
          $error("read_value: expected %h, got %h", exp_res.rd, act_res.rd);
          fail_cnt++;
        end
        if (act_res.cnt !== exp_res.cnt) begin
          $error("count: expected %0d, got %0d", exp_res.cnt, act_res.cnt);
          fail_cnt++;
        end
        if (act_res.empty !== exp_res.empty) begin
          $error("is_empty: expected %0b, got %0b", exp_res.empty, act_res.empty);
          fail_cnt++;
        end
      end
    end
  end

endmodule
